// ===== rtl/pwu_pkg.sv =====
`default_nettype none
package pwu_pkg;

    localparam int NUM_PARTICLES_DEF  = 64;
    localparam int NUM_OBJECTIVES_DEF = 4;
    localparam int MAX_OBJ   = 4;
    localparam int COMP_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int NOISE_W   = 16;
    localparam int INDEX_W   = 6;
    localparam int FUNC_W    = 2;
    localparam int U_W       = 32;
    localparam int QUO_W     = 63;
    localparam int DIV_STEPS = 63;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_RECORD  = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_UNIFORM = 2'd3
    } func_t;

    typedef logic [MAX_OBJ-1:0][COMP_W-1:0] comp_vec_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_WEIGHT,
        OUT_MEAN
    } out_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_W,
        ST_A_RD,
        ST_A_MUL,
        ST_A_U,
        ST_A_ACC,
        ST_DIV_START,
        ST_DIV,
        ST_B_RD,
        ST_B_M1,
        ST_B_M2,
        ST_B_W,
        ST_B_MEAN,
        ST_B_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     cnt_clr;
        logic     cnt_inc;
        logic     addr_item;
        logic     latch_item;
        logic     load_wr;
        logic     clear_wr;
        logic     rec_start;
        logic     a_mul;
        logic     a_u;
        logic     a_acc;
        logic     div_start;
        logic     div_step;
        logic     b_m1;
        logic     b_m2;
        logic     b_w;
        logic     b_mean;
        logic     b_acc;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/pwu_in_if.sv =====
`default_nettype none
interface pwu_in_if;
    import pwu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [INDEX_W-1:0]       index;
    logic signed [COMP_W-1:0] comp_0;
    logic signed [COMP_W-1:0] comp_1;
    logic signed [COMP_W-1:0] comp_2;
    logic signed [COMP_W-1:0] comp_3;
    logic                     answer;

    modport source (output valid, func, index, comp_0, comp_1, comp_2, comp_3, answer,
                    input ready);
    modport sink (input valid, func, index, comp_0, comp_1, comp_2, comp_3, answer,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/pwu_out_if.sv =====
`default_nettype none
interface pwu_out_if;
    import pwu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [WEIGHT_W-1:0]      weight;
    logic signed [COMP_W-1:0] mean_0;
    logic signed [COMP_W-1:0] mean_1;
    logic signed [COMP_W-1:0] mean_2;
    logic signed [COMP_W-1:0] mean_3;
    logic                     status;

    modport source (output valid, weight, mean_0, mean_1, mean_2, mean_3, status,
                    input ready);
    modport sink (input valid, weight, mean_0, mean_1, mean_2, mean_3, status,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/pwu_cfg_if.sv =====
`default_nettype none
interface pwu_cfg_if;
    import pwu_pkg::*;
    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwu_ram.sv =====
`default_nettype none
module pwu_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/pwu_ctrl.sv =====
`default_nettype none
module pwu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          in_func,
    output logic                     in_ready,
    input  wire pwu_pkg::stat_t      stat,
    output pwu_pkg::cmd_t            cmd
);
    import pwu_pkg::*;

    state_t   state_reg, state_next;
    out_sel_t sel_reg, sel_next;
    logic     reply_reg, reply_next;
    logic     accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sel_reg   <= OUT_ZERO;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        reply_next = reply_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.last)
                begin
                    state_next = reply_reg ? ST_OUT : ST_IDLE;
                    reply_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(in_func))
                        FUNC_LOAD:
                        begin
                            sel_next   = OUT_ZERO;
                            state_next = ST_OUT;
                        end
                        FUNC_RECORD:
                        begin
                            sel_next   = OUT_MEAN;
                            state_next = ST_A_RD;
                        end
                        FUNC_READ:
                        begin
                            sel_next   = OUT_WEIGHT;
                            state_next = ST_RD_W;
                        end
                        FUNC_UNIFORM:
                        begin
                            sel_next   = OUT_ZERO;
                            reply_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_W:      state_next = ST_OUT;
            ST_A_RD:      state_next = ST_A_MUL;
            ST_A_MUL:     state_next = ST_A_U;
            ST_A_U:       state_next = ST_A_ACC;
            ST_A_ACC:     state_next = stat.last ? ST_DIV_START : ST_A_RD;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_B_RD;
                end
            end
            ST_B_RD:      state_next = ST_B_M1;
            ST_B_M1:      state_next = ST_B_M2;
            ST_B_M2:      state_next = ST_B_W;
            ST_B_W:       state_next = ST_B_MEAN;
            ST_B_MEAN:    state_next = ST_B_ACC;
            ST_B_ACC:     state_next = stat.last ? ST_OUT : ST_B_RD;
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = sel_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = !stat.last;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_item = 1'b1;
                    cmd.cnt_clr    = 1'b1;
                    cmd.load_wr    = (func_t'(in_func) == FUNC_LOAD);
                    cmd.rec_start  = (func_t'(in_func) == FUNC_RECORD);
                end
            end
            ST_RD_W:      cmd.addr_item = 1'b1;
            ST_A_RD:      cmd.cnt_inc   = 1'b0;
            ST_A_MUL:     cmd.a_mul     = 1'b1;
            ST_A_U:       cmd.a_u       = 1'b1;
            ST_A_ACC:
            begin
                cmd.a_acc   = 1'b1;
                cmd.cnt_inc = !stat.last;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                cmd.cnt_clr   = 1'b1;
            end
            ST_DIV:       cmd.div_step = 1'b1;
            ST_B_RD:      cmd.cnt_inc  = 1'b0;
            ST_B_M1:      cmd.b_m1     = 1'b1;
            ST_B_M2:      cmd.b_m2     = 1'b1;
            ST_B_W:       cmd.b_w      = 1'b1;
            ST_B_MEAN:    cmd.b_mean   = 1'b1;
            ST_B_ACC:
            begin
                cmd.b_acc   = 1'b1;
                cmd.cnt_inc = !stat.last;
            end
            ST_OUT:
            begin
                cmd.addr_item = 1'b1;
                cmd.out_load  = stat.out_free;
            end
            default:      cmd.out_sel = sel_reg;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/pwu_dp.sv =====
`default_nettype none
module pwu_dp #(
    parameter int NUM_PARTICLES  = pwu_pkg::NUM_PARTICLES_DEF,
    parameter int NUM_OBJECTIVES = pwu_pkg::NUM_OBJECTIVES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [pwu_pkg::NOISE_W-1:0]   cfg_data,
    input  wire logic [pwu_pkg::INDEX_W-1:0]   in_index,
    input  wire pwu_pkg::comp_vec_t            in_comp,
    input  wire logic                          in_answer,
    input  wire pwu_pkg::cmd_t                 cmd,
    output pwu_pkg::stat_t                     stat,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [pwu_pkg::WEIGHT_W-1:0]       out_weight,
    output pwu_pkg::comp_vec_t                 out_mean,
    output logic                               out_status
);
    import pwu_pkg::*;

    localparam int N_W    = $clog2(NUM_PARTICLES);
    localparam int ROW_W  = NUM_OBJECTIVES * COMP_W;
    localparam int SUM_W  = U_W + N_W;
    localparam int ACC_W  = U_W + N_W + 1;
    localparam int PROD_W = 2 * COMP_W + 1;
    localparam int DOT_W  = 2 * COMP_W + 2;
    localparam int RLO_W  = 32;
    localparam int RHI_W  = QUO_W - RLO_W;
    localparam int FULL_W = U_W + QUO_W;
    localparam int SHR    = 46;
    localparam int SH_W   = ACC_W - COMP_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam logic [N_W-1:0]      LAST_IDX = N_W'(NUM_PARTICLES - 1);
    localparam logic [WEIGHT_W-1:0] UNIFORM  = WEIGHT_W'(65536 / NUM_PARTICLES);
    localparam logic [DCNT_W-1:0]   DIV_TOP  = DCNT_W'(DIV_STEPS - 1);
    localparam logic signed [SH_W-1:0] MEAN_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] MEAN_MIN = -SH_W'(32768);

    logic [NOISE_W-1:0]             noise_reg;
    logic [N_W-1:0]                 cnt_reg;
    logic [INDEX_W-1:0]             idx_reg;
    logic                           ans_reg;
    comp_vec_t                      diff_reg;
    logic signed [PROD_W-1:0]       prod_reg [MAX_OBJ];
    logic [WEIGHT_W-1:0]            w_reg;
    logic [U_W-1:0]                 u_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic signed [ACC_W-1:0]        acc_reg [MAX_OBJ];
    logic [SUM_W-1:0]               rem_reg;
    logic [QUO_W-1:0]               quo_reg;
    logic [DCNT_W-1:0]              dcnt_reg;
    logic [63:0]                    plo_reg;
    logic [RLO_W+RHI_W-2:0]         phi_reg;
    logic                           out_valid_reg;
    logic [WEIGHT_W-1:0]            out_weight_reg;
    comp_vec_t                      out_mean_reg;
    logic                           out_status_reg;

    logic [N_W-1:0]      raddr;
    logic [ROW_W-1:0]    p_q;
    logic [WEIGHT_W-1:0] w_q;
    logic [U_W-1:0]      u_q;
    logic [ROW_W-1:0]    load_row;
    logic                load_ok;
    logic                item_ok;
    logic                sum_zero;
    logic                w_we;
    logic [WEIGHT_W-1:0] w_wdata;
    logic [WEIGHT_W-1:0] w_new;
    logic [FULL_W-1:0]   full;
    logic [U_W:0]        uf;
    logic [16:0]         fac;
    logic signed [DOT_W-1:0] dot;
    logic [SUM_W:0]      rem_sh;
    logic                ge;
    logic [SUM_W:0]      rem_sub;

    assign load_ok  = (int'(in_index) < NUM_PARTICLES);
    assign item_ok  = (int'(idx_reg) < NUM_PARTICLES);
    assign sum_zero = (sum_reg == '0);
    assign raddr    = cmd.addr_item ? N_W'(idx_reg) : cnt_reg;

    always_comb
    begin
        for (int j = 0; j < NUM_OBJECTIVES; j++)
        begin
            load_row[j*COMP_W +: COMP_W] = in_comp[j];
        end
    end

    assign w_we    = cmd.clear_wr || (cmd.b_w && !sum_zero);
    assign w_wdata = cmd.clear_wr ? UNIFORM : w_new;

    pwu_ram #(.WIDTH(ROW_W), .DEPTH(NUM_PARTICLES)) u_prt_ram (
        .clk   (clk),
        .we    (cmd.load_wr && load_ok),
        .waddr (N_W'(in_index)),
        .wdata (load_row),
        .raddr (raddr),
        .rdata (p_q)
    );

    pwu_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_PARTICLES)) u_wgt_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (cnt_reg),
        .wdata (w_wdata),
        .raddr (raddr),
        .rdata (w_q)
    );

    pwu_ram #(.WIDTH(U_W), .DEPTH(NUM_PARTICLES)) u_u_ram (
        .clk   (clk),
        .we    (cmd.a_acc),
        .waddr (cnt_reg),
        .wdata (u_reg),
        .raddr (raddr),
        .rdata (u_q)
    );

    // sign of dot product and scaled weight
    always_comb
    begin
        dot = '0;
        for (int j = 0; j < NUM_OBJECTIVES; j++)
        begin
            dot = dot + DOT_W'(prod_reg[j]);
        end
        fac = ((!dot[DOT_W-1]) == ans_reg) ? (17'h10000 - 17'(noise_reg))
                                           : 17'(noise_reg);
        uf  = (U_W+1)'(w_q) * (U_W+1)'(fac);
    end

    // restoring divider step for 2^62 / sum
    always_comb
    begin
        rem_sh  = {rem_reg, (dcnt_reg == DIV_TOP)};
        ge      = (rem_sh >= {1'b0, sum_reg});
        rem_sub = rem_sh - {1'b0, sum_reg};
    end

    always_comb
    begin
        full  = {phi_reg, 32'b0} + FULL_W'(plo_reg);
        w_new = (|full[FULL_W-1:SHR+WEIGHT_W]) ? '1 : full[SHR +: WEIGHT_W];
    end

    assign stat.last     = (cnt_reg == LAST_IDX);
    assign stat.div_last = (dcnt_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                noise_reg <= cfg_data;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            idx_reg  <= in_index;
            ans_reg  <= in_answer;
            diff_reg <= in_comp;
        end
        if (cmd.rec_start)
        begin
            sum_reg <= '0;
            for (int j = 0; j < MAX_OBJ; j++)
            begin
                acc_reg[j] <= '0;
            end
        end
        if (cmd.a_mul)
        begin
            for (int j = 0; j < MAX_OBJ; j++)
            begin
                if (j < NUM_OBJECTIVES)
                begin
                    prod_reg[j] <= PROD_W'($signed(p_q[j*COMP_W +: COMP_W])
                                           * $signed(diff_reg[j]));
                end
                else
                begin
                    prod_reg[j] <= '0;
                end
            end
        end
        if (cmd.a_u)
        begin
            u_reg <= uf[U_W-1:0];
        end
        if (cmd.a_acc)
        begin
            sum_reg <= sum_reg + SUM_W'(u_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= DIV_TOP;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.b_m1)
        begin
            plo_reg <= 64'(u_q) * 64'(quo_reg[RLO_W-1:0]);
        end
        if (cmd.b_m2)
        begin
            phi_reg <= (RLO_W+RHI_W-1)'(u_q) * (RLO_W+RHI_W-1)'(quo_reg[QUO_W-1:RLO_W]);
        end
        if (cmd.b_w)
        begin
            w_reg <= sum_zero ? w_q : w_new;
        end
        if (cmd.b_mean)
        begin
            for (int j = 0; j < MAX_OBJ; j++)
            begin
                if (j < NUM_OBJECTIVES)
                begin
                    prod_reg[j] <= $signed({1'b0, w_reg})
                                   * $signed(p_q[j*COMP_W +: COMP_W]);
                end
                else
                begin
                    prod_reg[j] <= '0;
                end
            end
        end
        if (cmd.b_acc)
        begin
            for (int j = 0; j < MAX_OBJ; j++)
            begin
                acc_reg[j] <= acc_reg[j] + ACC_W'(prod_reg[j]);
            end
        end
        if (cmd.out_load)
        begin
            out_weight_reg <= '0;
            out_mean_reg   <= '0;
            out_status_reg <= 1'b0;
            case (cmd.out_sel)
                OUT_WEIGHT:
                begin
                    out_weight_reg <= item_ok ? w_q : '0;
                end
                OUT_MEAN:
                begin
                    out_status_reg <= sum_zero;
                    for (int j = 0; j < NUM_OBJECTIVES; j++)
                    begin
                        if ((acc_reg[j] >>> COMP_W) > ACC_W'(MEAN_MAX))
                        begin
                            out_mean_reg[j] <= 16'h7fff;
                        end
                        else if ((acc_reg[j] >>> COMP_W) < ACC_W'(MEAN_MIN))
                        begin
                            out_mean_reg[j] <= 16'h8000;
                        end
                        else
                        begin
                            out_mean_reg[j] <= acc_reg[j][COMP_W +: COMP_W];
                        end
                    end
                end
                default:
                begin
                    out_status_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_weight = out_weight_reg;
    assign out_mean   = out_mean_reg;
    assign out_status = out_status_reg;
endmodule
`default_nettype wire

// ===== rtl/particle_weight_update.sv =====
// Load, read weight and uniform reset each end by loading the result register; uniform reset first
// runs the clearing pass. Record runs a dot-product pass over the particles, the bit-serial
// reciprocal of the sum, and a pass for rescaling and the mean.
// One transaction in flight at a time; the result register lets the next item in early.
// rst_n is asynchronous, active low; after reset a clearing pass writes the uniform weight to
// every entry, and no item is taken until it ends.
`default_nettype none
module particle_weight_update #(
    parameter int NUM_PARTICLES  = pwu_pkg::NUM_PARTICLES_DEF,
    parameter int NUM_OBJECTIVES = pwu_pkg::NUM_OBJECTIVES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pwu_in_if.sink      item,
    pwu_out_if.source   result,
    pwu_cfg_if.sink     cfg
);
    import pwu_pkg::*;

    cmd_t      cmd;
    stat_t     stat;
    comp_vec_t comp;
    comp_vec_t mean;

    // the noise register takes a write in any cycle
    assign cfg.ready = 1'b1;

    assign comp = {item.comp_3, item.comp_2, item.comp_1, item.comp_0};

    // sequencer: walks the particle passes and the divider
    pwu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_func  (item.func),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores, multipliers, divider and the result register
    pwu_dp #(
        .NUM_PARTICLES  (NUM_PARTICLES),
        .NUM_OBJECTIVES (NUM_OBJECTIVES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .in_index   (item.index),
        .in_comp    (comp),
        .in_answer  (item.answer),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_weight (result.weight),
        .out_mean   (mean),
        .out_status (result.status)
    );

    assign result.mean_0 = mean[0];
    assign result.mean_1 = mean[1];
    assign result.mean_2 = mean[2];
    assign result.mean_3 = mean[3];

`ifndef NO_ASSERTIONS
    // a record transaction keeps the block busy on the following cycle
    a_record_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.func == FUNC_RECORD)) |=> !item.ready)
        else $error("input ready right after a record transaction");

    // the all-zero flag only comes with a record result, never with a weight
    a_status_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status) |-> (result.weight == '0))
        else $error("status set on a result carrying a weight");

    // no result is loaded as the clearing pass begins
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear_wr && !$past(cmd.clear_wr)) |-> !cmd.out_load)
        else $error("result loaded during the clearing pass");
`endif
endmodule
`default_nettype wire
